[rtl/core/esg_pkg.sv]
// ----------------------------------------------------------------------------
// esg_pkg: shared types and constants of the edge spring energy block
// Field widths, command and status codes, and the divider control group.
// ----------------------------------------------------------------------------
package esg_pkg;

  localparam int POS_W    = 32;
  localparam int IDX_W    = 10;
  localparam int GRAD_W   = 48;
  localparam int ENERGY_W = 63;
  // Edge length and stretch magnitude both stay below 2^34.
  localparam int LEN_W    = 34;
  localparam int DVD_W    = 66;

  localparam logic [ENERGY_W-1:0] ENERGY_MAX = {ENERGY_W{1'b1}};
  localparam logic [GRAD_W-1:0]   GRAD_MAX   = {1'b0, {(GRAD_W-1){1'b1}}};
  localparam logic [GRAD_W-1:0]   GRAD_MIN   = {1'b1, {(GRAD_W-1){1'b0}}};

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_ADD   = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_ZERO = 2'd1;
  localparam logic [1:0] STAT_SAT  = 2'd2;

  typedef struct packed {
    logic load;
    logic step;
  } div_ctrl_t;

endpackage

[rtl/core/esg_ram.sv]
// ----------------------------------------------------------------------------
// esg_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module esg_ram #(
  parameter int WIDTH = 144,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/esg_div.sv]
// ----------------------------------------------------------------------------
// esg_div: radix-2 restoring divider lane
// Divides a 66-bit dividend whose quotient fits in 34 bits, one bit a cycle while step is high.
// ----------------------------------------------------------------------------
module esg_div import esg_pkg::*; (
  input  logic              clk,
  input  div_ctrl_t         ctrl,
  input  logic [DVD_W-1:0]  dividend,
  input  logic [LEN_W-1:0]  divisor,
  output logic [LEN_W-1:0]  quot
);

  logic [LEN_W-1:0] rem;
  logic [LEN_W-1:0] shr;
  logic [LEN_W:0]   trial;
  logic [LEN_W:0]   diff;
  logic             fits;

  assign trial = {rem, shr[LEN_W-1]};
  assign diff  = trial - {1'b0, divisor};
  assign fits  = trial >= {1'b0, divisor};

  // The dividend's upper part is already below the divisor, so only the
  // low bits produce quotient bits; they shift in behind the dividend.
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      rem <= LEN_W'(dividend[DVD_W-1:LEN_W]);
      shr <= dividend[LEN_W-1:0];
    end else if (ctrl.step) begin
      rem <= fits ? diff[LEN_W-1:0] : trial[LEN_W-1:0];
      shr <= {shr[LEN_W-2:0], fits};
    end
  end

  assign quot = shr;

endmodule

[rtl/core/edge_spring_energy_gradient.sv]
// ----------------------------------------------------------------------------
// edge_spring_energy_gradient: spring energy and per-vertex gradient
// Accumulates edge spring energy and gradients in a vertex RAM.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. cmd selects clear,
// add edge or read gradient. Each request yields one result, shown on
// energy_sum, grad_x/y/z and status for exactly one cycle while done is high.
// The receiver cannot stall; results are held in output registers.
// Sequence (start accepted to done):
//   add edge: squares summed, the 34-step square root, energy term, gradient
//     products, the 34-step divider lanes, then vertex A and B updated.
//   zero-length edge: stops after the squares. read: one RAM read. unused
//   command: no work. clear: all VERTICES entries, one zeroed per cycle.
// Requests are serialized: a new one is taken once busy falls.
// After reset the block zeroes the energy at once and then runs a clearing
// pass over all VERTICES gradient RAM entries with busy high; that pass
// gives no result.
// ----------------------------------------------------------------------------
module edge_spring_energy_gradient import esg_pkg::*; #(
  parameter int VERTICES = 1024
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic [1:0]                cmd,
  input  logic [IDX_W-1:0]          vert_a,
  input  logic [IDX_W-1:0]          vert_b,
  input  logic signed [POS_W-1:0]   ax,
  input  logic signed [POS_W-1:0]   ay,
  input  logic signed [POS_W-1:0]   az,
  input  logic signed [POS_W-1:0]   bx,
  input  logic signed [POS_W-1:0]   by_pos,
  input  logic signed [POS_W-1:0]   bz,
  input  logic [POS_W-1:0]          rest_len,
  input  logic [IDX_W-1:0]          read_vertex,
  output logic                      done,
  output logic [ENERGY_W-1:0]       energy_sum,
  output logic signed [GRAD_W-1:0]  grad_x,
  output logic signed [GRAD_W-1:0]  grad_y,
  output logic signed [GRAD_W-1:0]  grad_z,
  output logic [1:0]                status
);

  localparam int AW   = $clog2(VERTICES);
  localparam int WORD = 3 * GRAD_W;

  typedef enum logic [15:0] {
    S_IDLE   = 16'h0001,
    S_CLEAR  = 16'h0002,
    S_SQ_MUL = 16'h0004,
    S_SQ_ACC = 16'h0008,
    S_SQRT   = 16'h0010,
    S_E_MUL  = 16'h0020,
    S_E_ACC  = 16'h0040,
    S_G_MUL  = 16'h0080,
    S_G_ACC  = 16'h0100,
    S_DIV    = 16'h0200,
    S_RD_A   = 16'h0400,
    S_WR_A   = 16'h0800,
    S_RD_B   = 16'h1000,
    S_WR_B   = 16'h2000,
    S_RD_V   = 16'h4000,
    S_FINISH = 16'h8000
  } state_t;

  state_t state;

  // Control registers.
  logic [AW-1:0]       clr_addr;
  logic                clr_req;
  logic [5:0]          step;
  logic [1:0]          sel;
  logic [ENERGY_W-1:0] energy_acc;

  // Request payload registers.
  cmd_t             cmd_r;
  logic [AW-1:0]    addr_a;
  logic [AW-1:0]    addr_b;
  logic [AW-1:0]    addr_rd;
  logic             a_in;
  logic             b_in;
  logic             rd_in;
  logic [POS_W-1:0] rest_r;
  logic [POS_W-1:0] mag [3];
  logic [2:0]       neg_d;
  logic             sat;
  logic [1:0]       stat_r;

  // Arithmetic registers.
  logic [DVD_W-1:0] sum;
  logic [DVD_W+1:0] op_sh;
  logic [LEN_W:0]   sq_rem;
  logic [LEN_W-1:0] root;
  logic [DVD_W-1:0] prod;

  // Request decode.
  logic [31:0]        idx_a;
  logic [31:0]        idx_b;
  logic [31:0]        idx_rd;
  logic signed [POS_W:0] diff_in [3];
  logic signed [POS_W-1:0] pa [3];
  logic signed [POS_W-1:0] pb [3];

  assign idx_a  = 32'(vert_a);
  assign idx_b  = 32'(vert_b);
  assign idx_rd = 32'(read_vertex);
  assign pa[0] = ax;
  assign pa[1] = ay;
  assign pa[2] = az;
  assign pb[0] = bx;
  assign pb[1] = by_pos;
  assign pb[2] = bz;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      diff_in[k] = {pa[k][POS_W-1], pa[k]} - {pb[k][POS_W-1], pb[k]};
    end
  end

  // Shared multiplier, registered output.
  logic [POS_W-1:0] mul_a;
  logic [LEN_W-1:0] mul_b;

  // Stretch e = L - rest and its magnitude.
  logic [LEN_W:0]   e_c;
  logic [LEN_W:0]   e_neg_val;
  logic             e_neg;
  logic [LEN_W-1:0] em;

  assign e_c       = {1'b0, root} - {3'b0, rest_r};
  assign e_neg     = e_c[LEN_W];
  assign e_neg_val = (LEN_W+1)'(0) - e_c;
  assign em        = e_neg ? e_neg_val[LEN_W-1:0] : e_c[LEN_W-1:0];

  always_comb begin
    mul_a = mag[sel];
    mul_b = em;
    case (state)
      S_SQ_MUL: mul_b = LEN_W'(mag[sel]);
      S_E_MUL:  begin
        mul_a = em[POS_W-1:0];
        mul_b = LEN_W'(em[POS_W-1:0]);
      end
      default:  mul_b = em;
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= {{(DVD_W-POS_W){1'b0}}, mul_a} * {{(DVD_W-LEN_W){1'b0}}, mul_b};
  end

  // Sum of squares.
  logic [DVD_W-1:0] sum_nx;
  assign sum_nx = sum + prod;

  // One square-root digit per cycle.
  logic [LEN_W+2:0] rt_rem;
  logic [LEN_W+2:0] rt_trial;
  logic [LEN_W+2:0] rt_diff;
  logic             rt_ge;

  assign rt_rem   = {sq_rem, op_sh[DVD_W+1:DVD_W]};
  assign rt_trial = {1'b0, root, 2'b01};
  assign rt_diff  = rt_rem - rt_trial;
  assign rt_ge    = rt_rem >= rt_trial;

  // Energy term and saturating accumulate.
  logic [ENERGY_W-1:0] term;
  logic                term_sat;
  logic [ENERGY_W:0]   e_sum;

  assign term_sat = |em[LEN_W-1:POS_W];
  assign term     = term_sat ? ENERGY_MAX : prod[2*POS_W-1:1];
  assign e_sum    = {1'b0, energy_acc} + {1'b0, term};

  // Divider lanes, one per axis.
  div_ctrl_t        dctrl [3];
  logic [LEN_W-1:0] quot [3];

  for (genvar g = 0; g < 3; g++) begin : g_lane
    assign dctrl[g].load = (state == S_G_ACC) && (sel == 2'(g));
    assign dctrl[g].step = (state == S_DIV);
    esg_div u_div (
      .clk      (clk),
      .ctrl     (dctrl[g]),
      .dividend (prod),
      .divisor  (root),
      .quot     (quot[g])
    );
  end

  // Signed gradient per axis: the sign of d times e.
  logic signed [LEN_W:0] gq [3];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (neg_d[k] ^ e_neg) begin
        gq[k] = (LEN_W+1)'(0) - {1'b0, quot[k]};
      end else begin
        gq[k] = {1'b0, quot[k]};
      end
    end
  end

  function automatic logic [GRAD_W:0] sat_add(input logic [GRAD_W-1:0] a,
                                              input logic [LEN_W:0] b);
    logic [GRAD_W:0] s;
    s = {a[GRAD_W-1], a} + {{(GRAD_W-LEN_W){b[LEN_W]}}, b};
    if (s[GRAD_W] != s[GRAD_W-1]) begin
      return s[GRAD_W] ? {1'b1, GRAD_MIN} : {1'b1, GRAD_MAX};
    end
    return {1'b0, s[GRAD_W-1:0]};
  endfunction

  // Vertex RAM: {z, y, x}.
  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  logic [WORD-1:0] ram_wdata;
  logic [AW-1:0]   ram_raddr;
  logic [WORD-1:0] ram_rdata;
  logic [WORD-1:0] rmw_word;
  logic            rmw_sat;

  always_comb begin
    logic [GRAD_W:0] r;
    logic [LEN_W:0]  b;
    rmw_word = '0;
    rmw_sat  = 1'b0;
    for (int k = 0; k < 3; k++) begin
      b = (state == S_WR_B) ? (LEN_W+1)'(0) - gq[k] : gq[k];
      r = sat_add(ram_rdata[k*GRAD_W +: GRAD_W], b);
      rmw_word[k*GRAD_W +: GRAD_W] = r[GRAD_W-1:0];
      rmw_sat = rmw_sat | r[GRAD_W];
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = addr_a;
    ram_wdata = rmw_word;
    ram_raddr = addr_a;
    case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = '0;
      end
      S_WR_A:  ram_we = a_in;
      S_RD_B:  ram_raddr = addr_b;
      S_WR_B:  begin
        ram_we    = b_in;
        ram_waddr = addr_b;
      end
      S_RD_V:  ram_raddr = addr_rd;
      default: ram_we = 1'b0;
    endcase
  end

  esg_ram #(
    .WIDTH (WORD),
    .DEPTH (VERTICES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_addr   <= '0;
      clr_req    <= 1'b0;
      step       <= '0;
      sel        <= '0;
      energy_acc <= '0;
      done       <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            cmd_r   <= cmd_t'(cmd);
            addr_a  <= idx_a[AW-1:0];
            addr_b  <= idx_b[AW-1:0];
            addr_rd <= idx_rd[AW-1:0];
            a_in    <= idx_a < 32'(VERTICES);
            b_in    <= idx_b < 32'(VERTICES);
            rd_in   <= idx_rd < 32'(VERTICES);
            rest_r  <= rest_len;
            for (int k = 0; k < 3; k++) begin
              neg_d[k] <= diff_in[k][POS_W];
              mag[k]   <= diff_in[k][POS_W] ? POS_W'(-diff_in[k])
                                            : diff_in[k][POS_W-1:0];
            end
            sat    <= 1'b0;
            stat_r <= STAT_OK;
            sum    <= '0;
            sel    <= '0;
            case (cmd_t'(cmd))
              CMD_CLEAR: begin
                energy_acc <= '0;
                clr_addr   <= '0;
                clr_req    <= 1'b1;
                state      <= S_CLEAR;
              end
              CMD_ADD:  state <= S_SQ_MUL;
              CMD_READ: state <= S_RD_V;
              default:  state <= S_FINISH;
            endcase
          end
        end
        S_CLEAR: begin
          if (clr_addr == AW'(VERTICES - 1)) begin
            clr_req <= 1'b0;
            state   <= clr_req ? S_FINISH : S_IDLE;
          end else begin
            clr_addr <= clr_addr + 1'b1;
          end
        end
        S_SQ_MUL: state <= S_SQ_ACC;
        S_SQ_ACC: begin
          sum <= sum_nx;
          if (sel == 2'd2) begin
            sel <= '0;
            if (sum_nx == '0) begin
              stat_r <= STAT_ZERO;
              state  <= S_FINISH;
            end else begin
              op_sh  <= {2'b00, sum_nx};
              sq_rem <= '0;
              root   <= '0;
              step   <= '0;
              state  <= S_SQRT;
            end
          end else begin
            sel   <= sel + 1'b1;
            state <= S_SQ_MUL;
          end
        end
        S_SQRT: begin
          sq_rem <= rt_ge ? rt_diff[LEN_W:0] : rt_rem[LEN_W:0];
          root   <= {root[LEN_W-2:0], rt_ge};
          op_sh  <= {op_sh[DVD_W-1:0], 2'b00};
          step   <= step + 1'b1;
          if (step == 6'(LEN_W - 1)) begin
            state <= S_E_MUL;
          end
        end
        S_E_MUL: state <= S_E_ACC;
        S_E_ACC: begin
          if (e_sum[ENERGY_W]) begin
            energy_acc <= ENERGY_MAX;
            sat        <= 1'b1;
          end else begin
            energy_acc <= e_sum[ENERGY_W-1:0];
            sat        <= sat | term_sat;
          end
          sel   <= '0;
          state <= S_G_MUL;
        end
        S_G_MUL: state <= S_G_ACC;
        S_G_ACC: begin
          if (sel == 2'd2) begin
            sel   <= '0;
            step  <= '0;
            state <= S_DIV;
          end else begin
            sel   <= sel + 1'b1;
            state <= S_G_MUL;
          end
        end
        S_DIV: begin
          step <= step + 1'b1;
          if (step == 6'(LEN_W - 1)) begin
            state <= S_RD_A;
          end
        end
        S_RD_A: state <= S_WR_A;
        S_WR_A: begin
          sat   <= sat | (a_in & rmw_sat);
          state <= S_RD_B;
        end
        S_RD_B: state <= S_WR_B;
        S_WR_B: begin
          if (sat | (b_in & rmw_sat)) begin
            stat_r <= STAT_SAT;
          end
          state <= S_FINISH;
        end
        S_RD_V: state <= S_FINISH;
        S_FINISH: begin
          done       <= 1'b1;
          energy_sum <= energy_acc;
          status     <= stat_r;
          if (cmd_r == CMD_READ && rd_in) begin
            grad_x <= ram_rdata[0*GRAD_W +: GRAD_W];
            grad_y <= ram_rdata[1*GRAD_W +: GRAD_W];
            grad_z <= ram_rdata[2*GRAD_W +: GRAD_W];
          end else begin
            grad_x <= '0;
            grad_y <= '0;
            grad_z <= '0;
          end
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while the block is busy");

  a_req_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

  a_we_state: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == S_CLEAR || state == S_WR_A || state == S_WR_B))
    else $error("RAM write outside clear or write-back");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (status == STAT_OK || status == STAT_ZERO || status == STAT_SAT))
    else $error("undefined status code");

  a_div_len: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (root != '0))
    else $error("division by a zero edge length");
`endif

endmodule

[test/edge_spring_energy_gradient_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// edge_spring_energy_gradient_tb: self-checking bench for the spring block
// Drives clear, add-edge, read and unused requests through the start/busy
// handshake, predicts each result with a fixed-point model of the spring
// energy and vertex gradients, and compares every done strobe in order.
// ----------------------------------------------------------------------------
module edge_spring_energy_gradient_tb;
  import esg_pkg::*;

  localparam int NVERT = 1024;

  typedef struct {
    logic [1:0]  cmd;
    logic [9:0]  va, vb, rv;
    logic [31:0] ax, ay, az, bx, by, bz, rest;
  } request_t;

  typedef struct {
    logic [62:0] energy;
    logic [47:0] gx, gy, gz;
    logic [1:0]  status;
  } answer_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy, done;
  logic [1:0] cmd = CMD_NOP;
  logic [9:0] vert_a = '0, vert_b = '0, read_vertex = '0;
  logic signed [31:0] ax = '0, ay = '0, az = '0, bx = '0, by_pos = '0, bz = '0;
  logic [31:0] rest_len = '0;
  logic [62:0] energy_sum;
  logic signed [47:0] grad_x, grad_y, grad_z;
  logic [1:0] status;

  edge_spring_energy_gradient uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .vert_a(vert_a), .vert_b(vert_b), .ax(ax), .ay(ay), .az(az),
    .bx(bx), .by_pos(by_pos), .bz(bz), .rest_len(rest_len),
    .read_vertex(read_vertex), .done(done), .energy_sum(energy_sum),
    .grad_x(grad_x), .grad_y(grad_y), .grad_z(grad_z), .status(status)
  );

  always #2 clk = ~clk;

  // Predicted state of the block.
  logic [63:0] energy_model;
  logic signed [47:0] gx_model [NVERT];
  logic signed [47:0] gy_model [NVERT];
  logic signed [47:0] gz_model [NVERT];

  request_t pending_requests[$];
  answer_t  expected_answers[$];
  int       mismatches = 0;
  int       idle_pct = 0;
  bit       taken = 1'b0;

  task automatic add_request(input request_t r);
    pending_requests = {pending_requests, r};
  endtask

  function automatic logic [47:0] sat_add(input logic signed [47:0] a,
                                          input logic signed [63:0] b,
                                          inout bit sat);
    logic signed [63:0] s;
    s = 64'(a) + b;
    if (s > 64'sd140737488355327) begin
      sat = 1'b1;
      return GRAD_MAX;
    end
    if (s < -64'sd140737488355328) begin
      sat = 1'b1;
      return GRAD_MIN;
    end
    return s[47:0];
  endfunction

  function automatic logic signed [63:0] axis_force(input logic signed [63:0] d,
                                                   input logic [63:0] em, input bit eneg,
                                                   input logic [63:0] len);
    logic [127:0] p;
    logic [63:0] q;
    p = 128'(d < 0 ? -d : d) * 128'(em);
    q = 64'(p / 128'(len));
    return ((d < 0) != eneg) ? -$signed(q) : $signed(q);
  endfunction

  function automatic answer_t predict_spring(input request_t r);
    answer_t a;
    logic signed [63:0] dx, dy, dz, e, px, py, pz;
    logic [127:0] ssq, c2;
    logic [63:0] len, em, term, c, mx, my, mz;
    bit sat;
    a.gx = '0; a.gy = '0; a.gz = '0; a.status = STAT_OK;
    sat = 1'b0;
    case (r.cmd)
      CMD_CLEAR: begin
        energy_model = '0;
        for (int i = 0; i < NVERT; i++) begin
          gx_model[i] = '0; gy_model[i] = '0; gz_model[i] = '0;
        end
      end
      CMD_ADD: begin
        dx = 64'($signed(r.ax)) - 64'($signed(r.bx));
        dy = 64'($signed(r.ay)) - 64'($signed(r.by));
        dz = 64'($signed(r.az)) - 64'($signed(r.bz));
        mx = dx < 0 ? -dx : dx;
        my = dy < 0 ? -dy : dy;
        mz = dz < 0 ? -dz : dz;
        ssq = 128'(mx * mx) + 128'(my * my) + 128'(mz * mz);
        if (ssq == 0) begin
          a.status = STAT_ZERO;
        end else begin
          len = '0;
          for (int b = 33; b >= 0; b--) begin
            c = len | (64'd1 << b);
            c2 = 128'(c) * 128'(c);
            if (c2 <= ssq) len = c;
          end
          e = $signed(len) - $signed({32'd0, r.rest});
          em = e < 0 ? -e : e;
          if (em >= 64'h1_0000_0000) begin
            term = 64'(ENERGY_MAX);
            sat = 1'b1;
          end else begin
            term = (em * em) >> 1;
          end
          if (term > 64'(ENERGY_MAX) - energy_model) begin
            energy_model = 64'(ENERGY_MAX);
            sat = 1'b1;
          end else begin
            energy_model += term;
          end
          px = axis_force(dx, em, e < 0, len);
          py = axis_force(dy, em, e < 0, len);
          pz = axis_force(dz, em, e < 0, len);
          gx_model[r.va] = sat_add(gx_model[r.va], px, sat);
          gy_model[r.va] = sat_add(gy_model[r.va], py, sat);
          gz_model[r.va] = sat_add(gz_model[r.va], pz, sat);
          gx_model[r.vb] = sat_add(gx_model[r.vb], -px, sat);
          gy_model[r.vb] = sat_add(gy_model[r.vb], -py, sat);
          gz_model[r.vb] = sat_add(gz_model[r.vb], -pz, sat);
          if (sat) a.status = STAT_SAT;
        end
      end
      CMD_READ: begin
        a.gx = gx_model[r.rv]; a.gy = gy_model[r.rv]; a.gz = gz_model[r.rv];
      end
      default: ;
    endcase
    a.energy = energy_model[62:0];
    return a;
  endfunction

  // The handshake is judged at the rising edge, where the block takes it.
  always @(posedge clk) begin
    taken <= start && !busy && !rst;
  end

  // Driver: inputs change on the falling edge; a request is held until taken.
  always @(negedge clk) begin
    request_t r;
    if (!rst) begin
      if (taken) begin
        r = pending_requests.pop_front();
        expected_answers = {expected_answers, predict_spring(r)};
      end
      if (taken || !start) begin
        if (pending_requests.size() != 0 &&
            $urandom_range(99, 0) >= idle_pct) begin
          r = pending_requests[0];
          cmd <= r.cmd; vert_a <= r.va; vert_b <= r.vb; read_vertex <= r.rv;
          ax <= r.ax; ay <= r.ay; az <= r.az;
          bx <= r.bx; by_pos <= r.by; bz <= r.bz; rest_len <= r.rest;
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor.
  always @(posedge clk) begin
    answer_t x;
    if (!rst && done) begin
      if (expected_answers.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result at %0t", $realtime);
      end else begin
        x = expected_answers.pop_front();
        if (energy_sum !== x.energy || grad_x !== x.gx || grad_y !== x.gy ||
            grad_z !== x.gz || status !== x.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp e=%h g=%h/%h/%h s=%0d got e=%h g=%h/%h/%h s=%0d",
                     x.energy, x.gx, x.gy, x.gz, x.status,
                     energy_sum, grad_x, grad_y, grad_z, status);
        end
      end
    end
  end

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(5, 0))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom_range(32'h0004_0000, 0) - 32'h0002_0000;
      3: return $urandom_range(32'h0400_0000, 0) - 32'h0200_0000;
      default: return $urandom();
    endcase
  endfunction

  function automatic request_t make_edge(input logic [31:0] ax_v, ay_v, az_v,
                                        bx_v, by_v, bz_v, rest_v,
                                        input logic [9:0] a_i, b_i);
    request_t r;
    r.cmd = CMD_ADD; r.va = a_i; r.vb = b_i; r.rv = 10'($urandom());
    r.ax = ax_v; r.ay = ay_v; r.az = az_v;
    r.bx = bx_v; r.by = by_v; r.bz = bz_v; r.rest = rest_v;
    return r;
  endfunction

  function automatic request_t make_cmd(input logic [1:0] c, input logic [9:0] v);
    request_t r;
    r = make_edge($urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                  $urandom(), $urandom(), 10'($urandom()), 10'($urandom()));
    r.cmd = c; r.rv = v;
    return r;
  endfunction

  task automatic drain();
    while (pending_requests.size() != 0 || expected_answers.size() != 0 || taken)
      @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  // Stimulus, in idling phases.
  initial begin
    request_t r;
    int pick;
    logic [9:0] hot;
    energy_model = '0;
    for (int i = 0; i < NVERT; i++) begin
      gx_model[i] = '0; gy_model[i] = '0; gz_model[i] = '0;
    end
    repeat (8) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // Directed: extremes, every command, zero length, same endpoints, saturation.
    add_request(make_cmd(CMD_READ, 10'd0));
    add_request(make_edge(32'h0001_0000, 0, 0, 0, 0, 0, 32'h0000_8000,
                          10'd1, 10'd2));
    add_request(make_cmd(CMD_READ, 10'd1));
    add_request(make_cmd(CMD_READ, 10'd2));
    add_request(make_edge(5, 6, 7, 5, 6, 7, 32'h1234, 10'd3, 10'd4));
    add_request(make_edge(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                          32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                          0, 10'd1023, 10'd0));
    add_request(make_edge(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                          32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                          32'hffff_ffff, 10'd1023, 10'd0));
    add_request(make_cmd(CMD_READ, 10'd1023));
    add_request(make_cmd(CMD_READ, 10'd0));
    add_request(make_edge(32'h0003_0000, 32'h0004_0000, 0, 0, 0, 0,
                          32'hffff_ffff, 10'd5, 10'd5));
    add_request(make_cmd(CMD_READ, 10'd5));
    add_request(make_cmd(CMD_NOP, 10'd5));
    add_request(make_edge(1, 0, 0, 0, 0, 0, 0, 10'd6, 10'd7));
    add_request(make_cmd(CMD_READ, 10'd7));
    add_request(make_cmd(CMD_CLEAR, 10'd0));
    add_request(make_cmd(CMD_READ, 10'd1023));
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 0) ? 0 : (ph == 3 ? 10 : 64);
      for (int n = 0; n < 430; n++) begin
        pick = $urandom_range(99, 0);
        hot = 10'($urandom_range(15, 0));
        if (pick < 2) r = make_cmd(CMD_CLEAR, 10'($urandom()));
        else if (pick < 4) r = make_cmd(CMD_NOP, 10'($urandom()));
        else if (pick < 25)
          r = make_cmd(CMD_READ, $urandom_range(1, 0) != 0 ? hot : 10'($urandom()));
        else begin
          r = make_edge(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                        rand_coord(), rand_coord(),
                        $urandom_range(3, 0) == 0 ? $urandom() : $urandom_range(32'h0008_0000, 0),
                        $urandom_range(3, 0) != 0 ? hot : 10'($urandom()),
                        $urandom_range(3, 0) != 0 ? 10'($urandom_range(15, 0))
                                                  : 10'($urandom()));
          if ($urandom_range(19, 0) == 0) begin
            r.bx = r.ax; r.by = r.ay; r.bz = r.az;
          end
        end
        add_request(r);
      end
      drain();
    end

    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
